### rtl/core/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants for the ray/triangle intersection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rti_pkg;

   // fraction bits of t
   localparam int T_FRAC = 16;

   // configuration register widths
   localparam int VERTEX_WIDTH   = 60;
   localparam int MATERIAL_WIDTH = 16;
   localparam int CSR_IDX_WIDTH  = 2;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_VERTEX_A,
      CSR_VERTEX_B,
      CSR_VERTEX_C,
      CSR_MATERIAL
   } csr_index_type;

   // outcome of the determinant tests, travels with each ray
   typedef struct packed {
      logic da_zero;   // degenerate / parallel
      logic db_pos;    // beta > 0
      logic dg_pos;    // gamma > 0
      logic sum_ok;    // beta + gamma < 1
      logic dt_neg;    // sign of t
   } flags_type;

endpackage

### rtl/core/ray_triangle_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core -- ray vs. one configured triangle, Cramer's rule
// Path: accepted request -> rti_det -> rti_div -> rti_resolve -> response reg.
// Throughput: one transaction per cycle unless stalled; bit-per-stage divider.
// Reset: synchronous; clears vertices, material and all valid bits, no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_triangle_intersect_core #(
   parameter int COORD_WIDTH = 20,
   parameter int T_WIDTH     = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_WIDTH-1:0]         req_origin_x,
   input  logic signed [COORD_WIDTH-1:0]         req_origin_y,
   input  logic signed [COORD_WIDTH-1:0]         req_origin_z,
   input  logic signed [COORD_WIDTH-1:0]         req_dir_x,
   input  logic signed [COORD_WIDTH-1:0]         req_dir_y,
   input  logic signed [COORD_WIDTH-1:0]         req_dir_z,
   input  logic signed [T_WIDTH-1:0]             req_min_t,
   input  logic signed [T_WIDTH-1:0]             req_closest_t,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic signed [T_WIDTH-1:0]             rsp_new_t,
   output logic [rti_pkg::MATERIAL_WIDTH-1:0]    rsp_hit_material,
   // configuration writes
   input  logic                                  csr_wr_en,
   input  logic [rti_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [rti_pkg::VERTEX_WIDTH-1:0]      csr_wr_data
);

   // Datapath: rti_det (7 stages) -> rti_div (T_WIDTH+1 stages)
   //           -> rti_resolve (1 stage) -> response register.
   // All stages share one advance enable: the pipe moves whenever the
   // response register is empty or being drained, so bubbles and stalls
   // never drop or duplicate a transaction.

   localparam int VW = 3 * COORD_WIDTH;
   localparam int DW = 3 * COORD_WIDTH + 6;
   localparam int XW = VW + rti_pkg::VERTEX_WIDTH;

   // configuration registers
   logic [rti_pkg::VERTEX_WIDTH-1:0]   vertex_a_ff, vertex_b_ff, vertex_c_ff;
   logic [rti_pkg::MATERIAL_WIDTH-1:0] material_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff <= '0;
         vertex_b_ff <= '0;
         vertex_c_ff <= '0;
         material_ff <= '0;
      end else if (csr_wr_en) begin
         case (rti_pkg::csr_index_type'(csr_index))
            rti_pkg::CSR_VERTEX_A: vertex_a_ff <= csr_wr_data;
            rti_pkg::CSR_VERTEX_B: vertex_b_ff <= csr_wr_data;
            rti_pkg::CSR_VERTEX_C: vertex_c_ff <= csr_wr_data;
            rti_pkg::CSR_MATERIAL: material_ff <= csr_wr_data[rti_pkg::MATERIAL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // vertex packing may be narrower or wider than the register; missing
   // upper bits read as zero
   logic [XW-1:0] va_x, vb_x, vc_x;
   assign va_x = {{VW{1'b0}}, vertex_a_ff};
   assign vb_x = {{VW{1'b0}}, vertex_b_ff};
   assign vc_x = {{VW{1'b0}}, vertex_c_ff};

   // pipeline advance
   logic rsp_valid_ff;
   logic en;
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // determinants
   logic                        det_valid;
   logic [DW-1:0]               det_da, det_dt;
   rti_pkg::flags_type          det_flags;
   logic signed [T_WIDTH-1:0]   det_tmin, det_tclose;

   rti_det #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_WIDTH     (T_WIDTH)
   ) u_det (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .vert_a    (va_x[VW-1:0]),
      .vert_b    (vb_x[VW-1:0]),
      .vert_c    (vc_x[VW-1:0]),
      .origin_x  (req_origin_x),
      .origin_y  (req_origin_y),
      .origin_z  (req_origin_z),
      .dir_x     (req_dir_x),
      .dir_y     (req_dir_y),
      .dir_z     (req_dir_z),
      .min_t     (req_min_t),
      .closest_t (req_closest_t),
      .out_valid (det_valid),
      .da_abs    (det_da),
      .dt_abs    (det_dt),
      .flags     (det_flags),
      .tmin      (det_tmin),
      .tclose    (det_tclose)
   );

   // t = |DT| * 2^16 / DA
   logic                        div_valid, div_ovf;
   logic [T_WIDTH-1:0]          div_quot;
   rti_pkg::flags_type          div_flags;
   logic signed [T_WIDTH-1:0]   div_tmin, div_tclose;

   rti_div #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_WIDTH     (T_WIDTH)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (det_valid),
      .da         (det_da),
      .dt_abs     (det_dt),
      .in_flags   (det_flags),
      .in_tmin    (det_tmin),
      .in_tclose  (det_tclose),
      .out_valid  (div_valid),
      .quot       (div_quot),
      .ovf        (div_ovf),
      .out_flags  (div_flags),
      .out_tmin   (div_tmin),
      .out_tclose (div_tclose)
   );

   // saturation and hit decision
   logic                        res_valid, res_hit;
   logic signed [T_WIDTH-1:0]   res_t;

   rti_resolve #(
      .T_WIDTH (T_WIDTH)
   ) u_resolve (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .quot      (div_quot),
      .ovf       (div_ovf),
      .flags     (div_flags),
      .tmin      (div_tmin),
      .tclose    (div_tclose),
      .out_valid (res_valid),
      .hit       (res_hit),
      .new_t     (res_t)
   );

   // response register
   logic                               rsp_hit_ff;
   logic signed [T_WIDTH-1:0]          rsp_new_t_ff;
   logic [rti_pkg::MATERIAL_WIDTH-1:0] rsp_material_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff      <= res_hit;
         rsp_new_t_ff    <= res_t;
         rsp_material_ff <= res_hit ? material_ff : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_new_t        = rsp_new_t_ff;
   assign rsp_hit_material = rsp_material_ff;

endmodule

### rtl/core/rti_det.sv
// ----------------------------------------------------------------------------
// rti_det
// Seven-stage pipeline forming the four Cramer determinants and their tests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rti_det #(
   parameter int COORD_WIDTH = 20,
   parameter int T_WIDTH     = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [3*COORD_WIDTH-1:0]        vert_a,
   input  logic [3*COORD_WIDTH-1:0]        vert_b,
   input  logic [3*COORD_WIDTH-1:0]        vert_c,
   input  logic signed [COORD_WIDTH-1:0]   origin_x,
   input  logic signed [COORD_WIDTH-1:0]   origin_y,
   input  logic signed [COORD_WIDTH-1:0]   origin_z,
   input  logic signed [COORD_WIDTH-1:0]   dir_x,
   input  logic signed [COORD_WIDTH-1:0]   dir_y,
   input  logic signed [COORD_WIDTH-1:0]   dir_z,
   input  logic signed [T_WIDTH-1:0]       min_t,
   input  logic signed [T_WIDTH-1:0]       closest_t,
   output logic                            out_valid,
   output logic [3*COORD_WIDTH+5:0]        da_abs,
   output logic [3*COORD_WIDTH+5:0]        dt_abs,
   output rti_pkg::flags_type              flags,
   output logic signed [T_WIDTH-1:0]       tmin,
   output logic signed [T_WIDTH-1:0]       tclose
);

   localparam int W   = COORD_WIDTH;
   localparam int EW  = W + 1;          // edge / offset width
   localparam int CW  = 2 * W + 3;      // cross product width
   localparam int CH  = CW / 2;         // signed high slice
   localparam int CL  = CW - CH;        // unsigned low slice
   localparam int DW  = 3 * W + 6;      // determinant width
   localparam int NST = 7;

   function automatic logic signed [CW-1:0] cross_c(
      input logic signed [EW-1:0] p1, input logic signed [EW-1:0] q1,
      input logic signed [EW-1:0] p2, input logic signed [EW-1:0] q2);
      return p1 * q1 - p2 * q2;
   endfunction

   logic [NST-1:0]             v_ff;
   logic signed [T_WIDTH-1:0]  tmin_ff   [NST];
   logic signed [T_WIDTH-1:0]  tclose_ff [NST];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tmin_ff[0]   <= min_t;
         tclose_ff[0] <= closest_t;
         for (int i = 1; i < NST; i++) begin
            tmin_ff[i]   <= tmin_ff[i-1];
            tclose_ff[i] <= tclose_ff[i-1];
         end
      end
   end

   // stage 1: edges, offset, direction
   logic signed [W-1:0]  org [3];
   logic signed [W-1:0]  dir [3];
   logic signed [EW-1:0] e1_in [3], e2_in [3], s_in [3], d_in [3];
   logic signed [EW-1:0] e1_ff [3], e2_ff [3], s_ff [3], d_ff [3];

   assign org[0] = origin_x;
   assign org[1] = origin_y;
   assign org[2] = origin_z;
   assign dir[0] = dir_x;
   assign dir[1] = dir_y;
   assign dir[2] = dir_z;

   always_comb begin
      logic signed [W-1:0] ca, cb, cc;
      for (int k = 0; k < 3; k++) begin
         ca       = $signed(vert_a[k*W +: W]);
         cb       = $signed(vert_b[k*W +: W]);
         cc       = $signed(vert_c[k*W +: W]);
         e1_in[k] = EW'(ca) - EW'(cb);
         e2_in[k] = EW'(ca) - EW'(cc);
         s_in[k]  = EW'(ca) - EW'(org[k]);
         d_in[k]  = EW'(dir[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         s_ff  <= s_in;
         d_ff  <= d_in;
      end
   end

   // stage 2: cross products e2 x d, s x d, e2 x s
   logic signed [CW-1:0] x1_in [3], x2_in [3], x3_in [3];
   logic signed [CW-1:0] x1_ff [3], x2_ff [3], x3_ff [3];
   logic signed [EW-1:0] e1_s2_ff [3], s_s2_ff [3];

   always_comb begin
      x1_in[0] = cross_c(e2_ff[1], d_ff[2], e2_ff[2], d_ff[1]);
      x1_in[1] = cross_c(e2_ff[2], d_ff[0], e2_ff[0], d_ff[2]);
      x1_in[2] = cross_c(e2_ff[0], d_ff[1], e2_ff[1], d_ff[0]);
      x2_in[0] = cross_c(s_ff[1],  d_ff[2], s_ff[2],  d_ff[1]);
      x2_in[1] = cross_c(s_ff[2],  d_ff[0], s_ff[0],  d_ff[2]);
      x2_in[2] = cross_c(s_ff[0],  d_ff[1], s_ff[1],  d_ff[0]);
      x3_in[0] = cross_c(e2_ff[1], s_ff[2], e2_ff[2], s_ff[1]);
      x3_in[1] = cross_c(e2_ff[2], s_ff[0], e2_ff[0], s_ff[2]);
      x3_in[2] = cross_c(e2_ff[0], s_ff[1], e2_ff[1], s_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= x1_in;
         x2_ff    <= x2_in;
         x3_ff    <= x3_in;
         e1_s2_ff <= e1_ff;
         s_s2_ff  <= s_ff;
      end
   end

   // stage 3: split products; dots are DA=e1.x1 DB=s.x1 DG=e1.x2 DT=e1.x3
   logic signed [EW-1:0]    u_sel [4][3];
   logic signed [CW-1:0]    x_sel [4][3];
   logic signed [EW+CH-1:0] ph_in [4][3], ph_ff [4][3];
   logic signed [EW+CL:0]   pl_in [4][3], pl_ff [4][3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_sel[0][k] = e1_s2_ff[k];
         x_sel[0][k] = x1_ff[k];
         u_sel[1][k] = s_s2_ff[k];
         x_sel[1][k] = x1_ff[k];
         u_sel[2][k] = e1_s2_ff[k];
         x_sel[2][k] = x2_ff[k];
         u_sel[3][k] = e1_s2_ff[k];
         x_sel[3][k] = x3_ff[k];
      end
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 3; k++) begin
            ph_in[j][k] = u_sel[j][k] * $signed(x_sel[j][k][CW-1:CL]);
            pl_in[j][k] = u_sel[j][k] * $signed({1'b0, x_sel[j][k][CL-1:0]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
   end

   // stage 4: recombine slices
   logic signed [DW-1:0] term_in [4][3], term_ff [4][3];

   always_comb begin
      logic signed [DW-1:0] hx, lx;
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 3; k++) begin
            hx            = DW'(ph_ff[j][k]);
            lx            = DW'(pl_ff[j][k]);
            term_in[j][k] = (hx <<< CL) + lx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= term_in;
      end
   end

   // stage 5: determinant sums
   logic signed [DW-1:0] det_in [4], det_ff [4];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         det_in[j] = term_ff[j][0] + term_ff[j][1] + term_ff[j][2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= det_in;
      end
   end

   // stage 6: make DA positive
   logic signed [DW-1:0] dn_in [4], dn_ff [4];
   logic                 daz_in, daz_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         dn_in[j] = det_ff[0][DW-1] ? -det_ff[j] : det_ff[j];
      end
      daz_in = (det_ff[0] == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dn_ff  <= dn_in;
         daz_ff <= daz_in;
      end
   end

   // stage 7: barycentric tests, |DT|
   rti_pkg::flags_type   flags_in, flags_ff;
   logic [DW-1:0]        da_abs_ff, dt_abs_ff;
   logic signed [DW+1:0] slack;

   always_comb begin
      slack            = (DW+2)'(dn_ff[0]) - (DW+2)'(dn_ff[1]) - (DW+2)'(dn_ff[2]);
      flags_in.da_zero = daz_ff;
      flags_in.db_pos  = !dn_ff[1][DW-1] && (dn_ff[1] != '0);
      flags_in.dg_pos  = !dn_ff[2][DW-1] && (dn_ff[2] != '0);
      flags_in.sum_ok  = !slack[DW+1] && (slack != '0);
      flags_in.dt_neg  = dn_ff[3][DW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff  <= flags_in;
         da_abs_ff <= dn_ff[0];
         dt_abs_ff <= dn_ff[3][DW-1] ? -dn_ff[3] : dn_ff[3];
      end
   end

   assign out_valid = v_ff[NST-1];
   assign da_abs    = da_abs_ff;
   assign dt_abs    = dt_abs_ff;
   assign flags     = flags_ff;
   assign tmin      = tmin_ff[NST-1];
   assign tclose    = tclose_ff[NST-1];

endmodule

### rtl/core/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, one quotient bit per stage, |DT|*2^16 / DA.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rti_div #(
   parameter int COORD_WIDTH = 20,
   parameter int T_WIDTH     = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [3*COORD_WIDTH+5:0]      da,
   input  logic [3*COORD_WIDTH+5:0]      dt_abs,
   input  rti_pkg::flags_type            in_flags,
   input  logic signed [T_WIDTH-1:0]     in_tmin,
   input  logic signed [T_WIDTH-1:0]     in_tclose,
   output logic                          out_valid,
   output logic [T_WIDTH-1:0]            quot,
   output logic                          ovf,
   output rti_pkg::flags_type            out_flags,
   output logic signed [T_WIDTH-1:0]     out_tmin,
   output logic signed [T_WIDTH-1:0]     out_tclose
);

   localparam int TW = T_WIDTH;
   localparam int DW = 3 * COORD_WIDTH + 6;
   localparam int NW = DW + rti_pkg::T_FRAC;
   localparam int NX = NW + TW;

   logic [TW:0]               v_ff;
   logic [DW-1:0]             rem_ff    [TW+1];
   logic [TW-1:0]             nlow_ff   [TW+1];
   logic [TW-1:0]             q_ff      [TW+1];
   logic [DW-1:0]             da_ff     [TW+1];
   logic                      ovf_ff    [TW+1];
   rti_pkg::flags_type        flags_ff  [TW+1];
   logic signed [TW-1:0]      tmin_ff   [TW+1];
   logic signed [TW-1:0]      tclose_ff [TW+1];

   // entry: overflow check, initial partial remainder
   logic [NX-1:0] nx;
   logic [NW-1:0] nhi;
   logic          ovf_in;

   assign nx     = {{TW{1'b0}}, dt_abs, {rti_pkg::T_FRAC{1'b0}}};
   assign nhi    = nx[NX-1:TW];
   assign ovf_in = (nhi >= {{rti_pkg::T_FRAC{1'b0}}, da});

   // bit stages
   logic [DW:0]   trial   [TW+1];
   logic [DW:0]   diff    [TW+1];
   logic          ge      [TW+1];
   logic [DW-1:0] rem_in  [TW+1];
   logic [TW-1:0] q_in    [TW+1];
   logic [TW-1:0] nlow_in [TW+1];

   always_comb begin
      trial[0]   = '0;
      diff[0]    = '0;
      ge[0]      = 1'b0;
      rem_in[0]  = nhi[DW-1:0];
      q_in[0]    = '0;
      nlow_in[0] = nx[TW-1:0];
      for (int k = 1; k <= TW; k++) begin
         trial[k]   = {rem_ff[k-1], nlow_ff[k-1][TW-1]};
         diff[k]    = trial[k] - {1'b0, da_ff[k-1]};
         ge[k]      = (trial[k] >= {1'b0, da_ff[k-1]});
         rem_in[k]  = ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
         q_in[k]    = {q_ff[k-1][TW-2:0], ge[k]};
         nlow_in[k] = {nlow_ff[k-1][TW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[TW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff    <= rem_in;
         nlow_ff   <= nlow_in;
         q_ff      <= q_in;
         da_ff[0]     <= da;
         ovf_ff[0]    <= ovf_in;
         flags_ff[0]  <= in_flags;
         tmin_ff[0]   <= in_tmin;
         tclose_ff[0] <= in_tclose;
         for (int k = 1; k <= TW; k++) begin
            da_ff[k]     <= da_ff[k-1];
            ovf_ff[k]    <= ovf_ff[k-1];
            flags_ff[k]  <= flags_ff[k-1];
            tmin_ff[k]   <= tmin_ff[k-1];
            tclose_ff[k] <= tclose_ff[k-1];
         end
      end
   end

   assign out_valid  = v_ff[TW];
   assign quot       = q_ff[TW];
   assign ovf        = ovf_ff[TW];
   assign out_flags  = flags_ff[TW];
   assign out_tmin   = tmin_ff[TW];
   assign out_tclose = tclose_ff[TW];

endmodule

### rtl/core/rti_resolve.sv
// ----------------------------------------------------------------------------
// rti_resolve
// Signs and saturates t, then applies the interval and barycentric tests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rti_resolve #(
   parameter int T_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [T_WIDTH-1:0]          quot,
   input  logic                        ovf,
   input  rti_pkg::flags_type          flags,
   input  logic signed [T_WIDTH-1:0]   tmin,
   input  logic signed [T_WIDTH-1:0]   tclose,
   output logic                        out_valid,
   output logic                        hit,
   output logic signed [T_WIDTH-1:0]   new_t
);

   localparam int TW = T_WIDTH;
   localparam logic [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
   localparam logic [TW-1:0] T_LOW = {1'b1, {(TW-1){1'b0}}};

   logic                 v_ff, ok_ff;
   logic signed [TW-1:0] t_in, t_ff, tmin_ff, tclose_ff;

   always_comb begin
      if (flags.dt_neg) begin
         t_in = (ovf || (quot > T_LOW)) ? T_LOW : (~quot + 1'b1);
      end else begin
         t_in = (ovf || quot[TW-1]) ? T_MAX : quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff      <= t_in;
         ok_ff     <= !flags.da_zero && flags.db_pos && flags.dg_pos && flags.sum_ok;
         tmin_ff   <= tmin;
         tclose_ff <= tclose;
      end
   end

   assign out_valid = v_ff;
   assign hit       = ok_ff && (t_ff > tmin_ff) && (t_ff < tclose_ff);
   assign new_t     = hit ? t_ff : tclose_ff;

endmodule

### rtl/core/rti_checker.sv
// ----------------------------------------------------------------------------
// rti_checker
// Port-level assertions for the intersection core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rti_checker #(
   parameter int T_WIDTH = 32
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_hit,
   input logic signed [T_WIDTH-1:0]           rsp_new_t,
   input logic [rti_pkg::MATERIAL_WIDTH-1:0]  rsp_hit_material
);

   localparam logic [T_WIDTH-1:0] T_LOW = {1'b1, {(T_WIDTH-1){1'b0}}};

   // held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_new_t) && $stable(rsp_hit_material))
      else $error("response changed while stalled");

   // request back pressure only comes from a blocked response
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without response back pressure");

   // a miss reports no material
   a_miss_mat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_material == '0)
      else $error("material reported on a miss");

   // t must exceed min_t, so a hit never carries the most negative code
   a_hit_t: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_new_t != T_LOW)
      else $error("hit with saturated low t");

   // pipeline empty right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ray_triangle_intersect_core rti_checker #(
   .T_WIDTH (T_WIDTH)
) u_rti_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_hit          (rsp_hit),
   .rsp_new_t        (rsp_new_t),
   .rsp_hit_material (rsp_hit_material)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top -- ray/triangle intersection core bench
// Loads triangles through the CSR port, streams rays through the core and
// checks every response against an exact determinant-based predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int CW        = 20;
   localparam int TW        = 32;
   localparam int LATENCY   = TW + 10;
   localparam int CYCLE_CAP = 400000;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [CW-1:0] ox, oy, oz, dx, dy, dz;
      logic signed [TW-1:0] min_t, closest_t;
   } ray_type;

   typedef struct {
      logic                 hit;
      logic signed [TW-1:0] new_t;
      logic [15:0]          mat;
   } hit_type;

   logic clock;
   logic reset = 1;

   logic                 req_valid = 0;
   logic                 req_stall;
   ray_type              ray_drv = '{default: '0};
   logic                 rsp_valid, rsp_stall = 0;
   logic                 rsp_hit;
   logic signed [TW-1:0] rsp_new_t;
   logic [15:0]          rsp_hit_material;
   logic                 csr_wr_en = 0;
   logic [1:0]           csr_index = rti_pkg::CSR_VERTEX_A;
   logic [59:0]          csr_wr_data = '0;

   // bench-side copy of the triangle registers
   logic [59:0] tri_a = '0, tri_b = '0, tri_c = '0;
   logic [15:0] tri_mat = '0;

   ray_type ray_q[$];   // rays waiting to be offered
   hit_type hit_q[$];   // predicted responses, oldest first
   int   errors = 0;
   int   cycles = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_go = 0, hold_seen = 0;
   int   hold_cnt = 0;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   ray_triangle_intersect_core #(.COORD_WIDTH(CW), .T_WIDTH(TW)) i_dut (
      .clock, .reset,
      .req_valid, .req_stall,
      .req_origin_x(ray_drv.ox), .req_origin_y(ray_drv.oy), .req_origin_z(ray_drv.oz),
      .req_dir_x(ray_drv.dx), .req_dir_y(ray_drv.dy), .req_dir_z(ray_drv.dz),
      .req_min_t(ray_drv.min_t), .req_closest_t(ray_drv.closest_t),
      .rsp_valid, .rsp_stall, .rsp_hit, .rsp_new_t, .rsp_hit_material,
      .csr_wr_en, .csr_index, .csr_wr_data
   );

   // --- predictor -----------------------------------------------------------
   function automatic wide_type coord(logic [59:0] v, int k);
      logic signed [CW-1:0] c;
      c = v[k*CW +: CW];
      return wide_type'(c);
   endfunction

   // u . (v x w), exact
   function automatic wide_type det3(wide_type u[3], wide_type v[3], wide_type w[3]);
      wide_type c0, c1, c2;
      c0 = v[1] * w[2] - v[2] * w[1];
      c1 = v[2] * w[0] - v[0] * w[2];
      c2 = v[0] * w[1] - v[1] * w[0];
      return u[0] * c0 + u[1] * c1 + u[2] * c2;
   endfunction

   function automatic hit_type predict_hit(ray_type r);
      wide_type e1[3], e2[3], d[3], s[3], pa[3];
      wide_type da, db, dg, dt;
      logic [127:0] mag, quo;
      logic signed [63:0] t;
      hit_type h;
      h.hit = 0;
      h.new_t = r.closest_t;
      h.mat = '0;
      for (int k = 0; k < 3; k++) begin
         pa[k] = coord(tri_a, k);
         e1[k] = pa[k] - coord(tri_b, k);
         e2[k] = pa[k] - coord(tri_c, k);
      end
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      s[0] = pa[0] - wide_type'(r.ox);
      s[1] = pa[1] - wide_type'(r.oy);
      s[2] = pa[2] - wide_type'(r.oz);
      da = det3(e1, e2, d);
      if (da == 0) return h;   // degenerate or parallel ray
      db = det3(s, e2, d);
      dg = det3(e1, s, d);
      dt = det3(e1, e2, s);
      if (da < 0) begin
         da = -da; db = -db; dg = -dg; dt = -dt;
      end
      if (db > 0 && dg > 0 && (da - (db + dg)) > 0) begin
         mag = (dt < 0) ? -dt : dt;
         quo = (mag << rti_pkg::T_FRAC) / da;
         if (dt < 0)
            t = (quo > 128'h8000_0000) ? -64'sh8000_0000 : -$signed(64'(quo));
         else
            t = (quo > 128'h7FFF_FFFF) ? 64'sh7FFF_FFFF : $signed(64'(quo));
         if (t > r.min_t && t < r.closest_t) begin
            h.hit = 1;
            h.new_t = t[TW-1:0];
            h.mat = tri_mat;
         end
      end
      return h;
   endfunction

   // --- request driver --------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) hit_q.push_back(predict_hit(ray_drv));   // transaction taken
         if (ray_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            ray_drv <= ray_q.pop_front();
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // --- response monitor ------------------------------------------------------
   always @(posedge clock) begin
      hit_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hit_q.size() == 0) begin
            $display("%0t: unexpected response hit=%0b t=%0d mat=%0d", $time,
                     rsp_hit, rsp_new_t, rsp_hit_material);
            errors++;
         end else begin
            e = hit_q.pop_front();
            if (rsp_hit !== e.hit) begin
               $display("%0t: hit exp %0b act %0b", $time, e.hit, rsp_hit);
               errors++;
            end
            if (rsp_new_t !== e.new_t) begin
               $display("%0t: new_t exp %0d act %0d", $time, e.new_t, rsp_new_t);
               errors++;
            end
            if (rsp_hit_material !== e.mat) begin
               $display("%0t: hit_material exp %0d act %0d", $time, e.mat,
                        rsp_hit_material);
               errors++;
            end
         end
      end
   end

   // --- stall generator: long hold-off fills the block and stalls its input --
   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_cnt <= 300;
         rsp_stall <= 1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // --- stimulus helpers ------------------------------------------------------
   function automatic logic [59:0] pack(int x, int y, int z);
      logic [CW-1:0] px, py, pz;
      px = CW'(x); py = CW'(y); pz = CW'(z);
      return {pz, py, px};
   endfunction

   function automatic ray_type mk(int ox, int oy, int oz, int dx, int dy, int dz,
                                  int mn, int cl);
      ray_type r;
      r.ox = CW'(ox); r.oy = CW'(oy); r.oz = CW'(oz);
      r.dx = CW'(dx); r.dy = CW'(dy); r.dz = CW'(dz);
      r.min_t = mn; r.closest_t = cl;
      return r;
   endfunction

   function automatic int rnd_c(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   // wait until nothing is in flight, then let the pipeline settle
   task automatic drain();
      do @(negedge clock);
      while (ray_q.size() != 0 || req_valid || hit_q.size() != 0);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic load_triangle(logic [59:0] a, logic [59:0] b, logic [59:0] c,
                                logic [59:0] m);
      drain();
      @(posedge clock);
      csr_wr_en <= 1; csr_index <= rti_pkg::CSR_VERTEX_A; csr_wr_data <= a;
      @(posedge clock);
      csr_index <= rti_pkg::CSR_VERTEX_B; csr_wr_data <= b;
      @(posedge clock);
      csr_index <= rti_pkg::CSR_VERTEX_C; csr_wr_data <= c;
      @(posedge clock);
      csr_index <= rti_pkg::CSR_MATERIAL; csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 0;
      tri_a = a; tri_b = b; tri_c = c; tri_mat = m[15:0];
   endtask

   // rays aimed at a random point in or near the loaded triangle, plus noise
   task automatic random_rays(int n, int noise_pct);
      int ta[3], tb[3], tc[3], tgt[3], o[3], u, v, mn, cl;
      ray_type r;
      for (int k = 0; k < 3; k++) begin
         ta[k] = int'(coord(tri_a, k));
         tb[k] = int'(coord(tri_b, k));
         tc[k] = int'(coord(tri_c, k));
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct) begin
            r = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
         end else begin
            u = $urandom_range(130);
            v = $urandom_range(130);
            for (int k = 0; k < 3; k++) begin
               tgt[k] = ta[k] + (u * (tb[k] - ta[k]) + v * (tc[k] - ta[k])) / 256;
               o[k] = rnd_c(16384);
            end
            case ($urandom_range(3))
               0: mn = $urandom;
               1: mn = -$urandom_range(100000);
               default: mn = 0;
            endcase
            case ($urandom_range(3))
               0: cl = $urandom_range(131072);
               1: cl = $urandom;
               default: cl = 32'h7FFF_FFFF;
            endcase
            r = mk(o[0], o[1], o[2], tgt[0] - o[0], tgt[1] - o[1], tgt[2] - o[2],
                   mn, cl);
         end
         ray_q.push_back(r);
      end
   endtask

   // --- test sequence ---------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;

      // reset state: all-zero triangle, every ray is degenerate
      ray_q.push_back(mk(100, 200, 300, 1, 2, 3, 0, 1000));

      // triangle in the plane z = 1024
      load_triangle(pack(0, 0, 1024), pack(4096, 0, 1024), pack(0, 4096, 1024),
                    60'hFFF_FFFF_FFFF_1234);
      ray_q.push_back(mk(512, 512, 0, 0, 0, 1024, 0, 32'h7FFF_FFFF));   // hit, t=1
      ray_q.push_back(mk(512, 512, 0, 256, 0, 0, 0, 32'h7FFF_FFFF));    // parallel
      ray_q.push_back(mk(0, 512, 0, 0, 0, 1024, 0, 32'h7FFF_FFFF));     // on edge ac
      ray_q.push_back(mk(512, 0, 0, 0, 0, 1024, 0, 32'h7FFF_FFFF));     // on edge ab
      ray_q.push_back(mk(2048, 2048, 0, 0, 0, 1024, 0, 32'h7FFF_FFFF)); // on edge bc
      ray_q.push_back(mk(4000, 4000, 0, 0, 0, 1024, 0, 32'h7FFF_FFFF)); // outside
      ray_q.push_back(mk(512, 512, 0, 0, 0, 1024, 65536, 65536));       // empty interval
      ray_q.push_back(mk(512, 512, 0, 0, 0, 1024, 70000, 1000));        // empty interval
      ray_q.push_back(mk(512, 512, 0, 0, 0, 1024, 0, 65536));           // t == closest
      ray_q.push_back(mk(512, 512, 0, 0, 0, 1024, 65536, 32'h7FFF_FFFF)); // t == min
      ray_q.push_back(mk(512, 512, 0, 0, 0, 1024, 65535, 65537));       // just inside
      ray_q.push_back(mk(512, 512, 0, 0, 0, -1024, 32'h8000_0000, 0));  // negative t
      ray_q.push_back(mk(512, 512, 0, 0, 0, 3, 0, 32'h7FFF_FFFF));      // t rounds down
      ray_q.push_back(mk(512, 512, -524288, 0, 0, 1, 0, 32'h7FFF_FFFF)); // saturate high
      ray_q.push_back(mk(512, 512, -524288, 0, 0, 1, 0, 32'h8000_0000)); // saturate, miss
      ray_q.push_back(mk(512, 512, 524287, 0, 0, -1, 32'h8000_0000,
                         32'h7FFF_FFFF));                               // saturate high
      ray_q.push_back(mk(512, 512, -524288, 0, 0, -1, 32'h8000_0000,
                         32'h7FFF_FFFF));                               // saturate low
      ray_q.push_back(mk(524287, 524287, 524287, 524287, 524287, 524287,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF));
      ray_q.push_back(mk(-524288, -524288, -524288, -524288, -524288, -524288,
                         32'h8000_0000, 32'h8000_0000));
      ray_q.push_back(mk(1000, 500, 5000, 0, 0, -1024, 0, 32'h7FFF_FFFF)); // from above

      // random triangles under each idling pattern
      for (int ph = 0; ph < 5; ph++) begin
         load_triangle(pack(rnd_c(16384), rnd_c(16384), rnd_c(16384)),
                       pack(rnd_c(16384), rnd_c(16384), rnd_c(16384)),
                       pack(rnd_c(16384), rnd_c(16384), rnd_c(16384)),
                       60'({$urandom, $urandom}));
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 67; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 67; end
            3: begin send_idle_pct = 33; rsp_stall_pct = 33; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 10; end
         endcase
         random_rays(110, 20);
         if (ph == 4) begin
            repeat (20) @(negedge clock);
            hold_go = ~hold_go;      // receiver holds off while rays keep coming
         end
      end

      // extreme triangles: corners at the coordinate limits, full random vertices
      send_idle_pct = 20; rsp_stall_pct = 20;
      load_triangle(pack(524287, -524288, 524287), pack(-524288, 524287, -524288),
                    pack(524287, 524287, -524288), 60'h0);
      random_rays(40, 60);
      load_triangle(60'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                    60'({$urandom, $urandom}), 60'hFFFF);
      random_rays(40, 60);
      load_triangle(pack(-524288, -524288, -524288), pack(524287, 524287, 524287),
                    pack(-524288, 524287, -524288), 60'({$urandom, $urandom}));
      random_rays(40, 60);
      load_triangle({60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}});   // degenerate
      random_rays(15, 100);

      drain();
      if (hit_q.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, hit_q.size());
         errors++;
      end
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
rtl/core/rti_pkg.sv
rtl/core/rti_det.sv
rtl/core/rti_div.sv
rtl/core/rti_resolve.sv
rtl/core/ray_triangle_intersect_core.sv
rtl/core/rti_checker.sv
bench/tb_top.sv
